// ----- src/sbwr_pkg.sv -----
`timescale 1ns / 1ps
package sbwr_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int RAMP_EXTRA     = 29 - GAIN_FRAC_BITS;
  localparam int RAMP_BITS      = 32;
  localparam int LEN_BITS       = 13;
  localparam int POS_BITS       = 12;
  localparam int MAX_FRAMES     = 4096;
  localparam int FPB_RESET      = 1024;

  // Ramp differences reach 2^30 in magnitude, so the quotient has 31 bits.
  localparam int DIV_STEPS      = 31;
  localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;
  typedef logic signed [RAMP_BITS-1:0]   ramp_t;
  typedef logic [LEN_BITS-1:0]           len_t;

  localparam gain_t GAIN_ONE = gain_t'(1 << GAIN_FRAC_BITS);
  localparam ramp_t RAMP_ONE = ramp_t'(1 << (GAIN_FRAC_BITS + RAMP_EXTRA));

  // One frame handed from the gain generator to the mixing datapath.
  typedef struct packed {
    sample_t left;
    sample_t right;
    gain_t   bal;
    gain_t   wid;
  } frame_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

endpackage

// ----- src/sbwr_div.sv -----
`timescale 1ns / 1ps
module sbwr_div
  import sbwr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  ramp_t dividend,
  input  len_t  divisor,
  output logic  done,
  output ramp_t quotient
);

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [DIV_STEPS-1:0]    quo_r;
  logic [LEN_BITS-1:0]     rem_r;
  logic [LEN_BITS-1:0]     den_r;
  logic                    neg_r;

  logic [DIV_STEPS-1:0]    mag;
  logic [LEN_BITS:0]       trial;
  logic                    ge;
  logic [LEN_BITS-1:0]     rem_nxt;

  // Sign and magnitude, so the quotient truncates toward zero.
  assign mag     = dividend[RAMP_BITS-1] ? DIV_STEPS'(-dividend) : dividend[DIV_STEPS-1:0];
  assign trial   = {rem_r, quo_r[DIV_STEPS-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? LEN_BITS'(trial - {1'b0, den_r}) : trial[LEN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      den_r <= divisor;
      neg_r <= dividend[RAMP_BITS-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_STEPS-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

// ----- src/sbwr_front.sv -----
`timescale 1ns / 1ps
module sbwr_front
  import sbwr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  len_t    frames_per_buffer,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t left_in,
  input  sample_t right_in,
  input  gain_t   target_balance,
  input  gain_t   target_width,
  input  logic    fading_out,
  output logic    push,
  output frame_t  push_data,
  input  logic    full
);

  front_state_t        state_r, state_nxt;
  logic [POS_BITS-1:0] pos_r;
  gain_t               prev_bal_r, prev_wid_r;
  ramp_t               step_bal_r, step_wid_r;
  ramp_t               now_bal_r, now_wid_r;
  sample_t             hold_l_r, hold_r_r;
  gain_t               tgt_bal_r, tgt_wid_r;

  len_t    n_len;
  logic    accept, first, last, process;
  gain_t   tb, tw;
  ramp_t   d_bal, d_wid, q_bal, q_wid;
  logic    done_bal, done_wid;
  gain_t   g_bal, g_wid;
  ramp_t   adv_bal, adv_wid;

  function automatic gain_t clamp_target(input gain_t v);
    if (v > GAIN_ONE) begin
      return GAIN_ONE;
    end else if (v < -GAIN_ONE) begin
      return -GAIN_ONE;
    end
    return v;
  endfunction

  // Round half up to whole gain steps, then clamp to plus or minus one.
  function automatic gain_t ramp_gain(input ramp_t now);
    logic signed [RAMP_BITS:0]               rn;
    logic signed [RAMP_BITS-RAMP_EXTRA:0]    g;
    rn = (RAMP_BITS+1)'(now) + (RAMP_BITS+1)'(1 << (RAMP_EXTRA - 1));
    g  = rn[RAMP_BITS:RAMP_EXTRA];
    if (g > (RAMP_BITS-RAMP_EXTRA+1)'(GAIN_ONE)) begin
      return GAIN_ONE;
    end else if (g < -(RAMP_BITS-RAMP_EXTRA+1)'(GAIN_ONE)) begin
      return -GAIN_ONE;
    end
    return GAIN_BITS'(g);
  endfunction

  function automatic ramp_t advance(input ramp_t now, input ramp_t step);
    logic signed [RAMP_BITS:0] s;
    s = (RAMP_BITS+1)'(now) + (RAMP_BITS+1)'(step);
    if (s > (RAMP_BITS+1)'(RAMP_ONE)) begin
      return RAMP_ONE;
    end else if (s < -(RAMP_BITS+1)'(RAMP_ONE)) begin
      return -RAMP_ONE;
    end
    return RAMP_BITS'(s);
  endfunction

  always_comb begin
    if (frames_per_buffer == '0) begin
      n_len = len_t'(1);
    end else if (frames_per_buffer > len_t'(MAX_FRAMES)) begin
      n_len = len_t'(MAX_FRAMES);
    end else begin
      n_len = frames_per_buffer;
    end
  end

  assign in_ready = (state_r == FR_IDLE) && !full;
  assign accept   = in_valid && in_ready;
  assign first    = (pos_r == '0);
  assign last     = (LEN_BITS'(pos_r) + len_t'(1)) >= n_len;

  assign tb = fading_out ? '0 : clamp_target(target_balance);
  assign tw = fading_out ? '0 : clamp_target(target_width);

  assign d_bal = (RAMP_BITS'(tb) - RAMP_BITS'(prev_bal_r)) <<< RAMP_EXTRA;
  assign d_wid = (RAMP_BITS'(tw) - RAMP_BITS'(prev_wid_r)) <<< RAMP_EXTRA;

  sbwr_div u_div_bal (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && first),
    .dividend (d_bal),
    .divisor  (n_len),
    .done     (done_bal),
    .quotient (q_bal)
  );

  sbwr_div u_div_wid (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && first),
    .dividend (d_wid),
    .divisor  (n_len),
    .done     (done_wid),
    .quotient (q_wid)
  );

  assign g_bal   = last ? prev_bal_r : ramp_gain(now_bal_r);
  assign g_wid   = last ? prev_wid_r : ramp_gain(now_wid_r);
  assign adv_bal = advance(now_bal_r, step_bal_r);
  assign adv_wid = advance(now_wid_r, step_wid_r);

  assign process = ((state_r == FR_IDLE) && accept && !first) ||
                   ((state_r == FR_PUSH) && !full);

  always_comb begin
    push            = process;
    push_data.left  = (state_r == FR_PUSH) ? hold_l_r : left_in;
    push_data.right = (state_r == FR_PUSH) ? hold_r_r : right_in;
    push_data.bal   = g_bal;
    push_data.wid   = g_wid;
    state_nxt       = state_r;
    case (state_r)
      FR_IDLE: begin
        if (accept && first) begin
          state_nxt = FR_DIV;
        end
      end
      FR_DIV: begin
        if (done_bal && done_wid) begin
          state_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!full) begin
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FR_IDLE;
      pos_r      <= '0;
      prev_bal_r <= '0;
      prev_wid_r <= '0;
      step_bal_r <= '0;
      step_wid_r <= '0;
      now_bal_r  <= '0;
      now_wid_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == FR_DIV) && done_bal && done_wid) begin
        step_bal_r <= q_bal;
        step_wid_r <= q_wid;
        now_bal_r  <= (RAMP_BITS'(prev_bal_r) <<< RAMP_EXTRA) + q_bal;
        now_wid_r  <= (RAMP_BITS'(prev_wid_r) <<< RAMP_EXTRA) + q_wid;
        prev_bal_r <= tgt_bal_r;
        prev_wid_r <= tgt_wid_r;
      end else if (process) begin
        if (last) begin
          pos_r <= '0;
        end else begin
          pos_r     <= pos_r + 1'b1;
          now_bal_r <= adv_bal;
          now_wid_r <= adv_wid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && first) begin
      hold_l_r  <= left_in;
      hold_r_r  <= right_in;
      tgt_bal_r <= tb;
      tgt_wid_r <= tw;
    end
  end

endmodule

// ----- src/sbwr_fifo.sv -----
`timescale 1ns / 1ps
module sbwr_fifo
  import sbwr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output frame_t pop_data,
  output logic   empty
);

  frame_t                   mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_BITS:0]   count_r;

  assign full     = (count_r == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/sbwr_back.sv -----
`timescale 1ns / 1ps
module sbwr_back
  import sbwr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  output logic    pop,
  input  frame_t  pop_data,
  input  logic    empty,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t left_out,
  output sample_t right_out
);

  localparam int SUM_BITS  = SAMPLE_BITS + 1;
  localparam int PA_BITS   = SUM_BITS + GAIN_BITS;
  localparam int MS_BITS   = PA_BITS + 1;
  localparam int HALF_BITS = SAMPLE_BITS + 3;
  localparam int PL_BITS   = HALF_BITS + GAIN_BITS;
  localparam int RND_BITS  = PL_BITS - GAIN_FRAC_BITS;

  logic en;
  logic v1_r, v2_r, v3_r, out_valid_r;

  logic signed [PA_BITS-1:0]   pa_r, pb_r;
  gain_t                       bal1_r;
  logic signed [HALF_BITS-1:0] lh_r, rh_r;
  gain_t                       cl_r, cr_r;
  logic signed [PL_BITS-1:0]   pl_r, pr_r;
  sample_t                     left_r, right_r;

  logic signed [SUM_BITS-1:0]  sum, dif;
  gain_t                       ga, gb, cl, cr;
  logic signed [PA_BITS-1:0]   pa, pb;
  logic signed [MS_BITS-1:0]   ml, mr;
  logic signed [PL_BITS-1:0]   pl, pr;
  logic signed [RND_BITS-1:0]  ol, orr;

  function automatic sample_t sat(input logic signed [RND_BITS-1:0] v);
    if (v > RND_BITS'(sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (v < RND_BITS'(sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}}))) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end
    return SAMPLE_BITS'(v);
  endfunction

  // The whole pipe moves unless a finished word is held at the output.
  assign en  = !out_valid_r || out_ready;
  assign pop = en && !empty;

  // Stage one: width gain on mid (L+R) and side (R-L).
  assign sum = SUM_BITS'(pop_data.left) + SUM_BITS'(pop_data.right);
  assign dif = SUM_BITS'(pop_data.right) - SUM_BITS'(pop_data.left);
  assign ga  = (pop_data.wid > 0) ? GAIN_ONE - pop_data.wid : GAIN_ONE;
  assign gb  = (pop_data.wid > 0) ? GAIN_ONE : GAIN_ONE + pop_data.wid;
  assign pa  = sum * ga;
  assign pb  = dif * gb;

  // Stage two: rebuild left and right, halving folded into the rounding.
  assign ml = MS_BITS'(pa_r) - MS_BITS'(pb_r) + MS_BITS'(1 << GAIN_FRAC_BITS);
  assign mr = MS_BITS'(pa_r) + MS_BITS'(pb_r) + MS_BITS'(1 << GAIN_FRAC_BITS);
  assign cl = (bal1_r > 0) ? GAIN_ONE - bal1_r : GAIN_ONE;
  assign cr = (bal1_r > 0) ? GAIN_ONE : GAIN_ONE + bal1_r;

  // Stage three: balance gain.
  assign pl = lh_r * cl_r;
  assign pr = rh_r * cr_r;

  // Stage four: round and saturate.
  assign ol  = RND_BITS'((pl_r + PL_BITS'(1 << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS);
  assign orr = RND_BITS'((pr_r + PL_BITS'(1 << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= !empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r    <= pa;
      pb_r    <= pb;
      bal1_r  <= pop_data.bal;
      lh_r    <= HALF_BITS'(ml >>> (GAIN_FRAC_BITS + 1));
      rh_r    <= HALF_BITS'(mr >>> (GAIN_FRAC_BITS + 1));
      cl_r    <= cl;
      cr_r    <= cr;
      pl_r    <= pl;
      pr_r    <= pr;
      left_r  <= sat(ol);
      right_r <= sat(orr);
    end
  end

  assign out_valid = out_valid_r;
  assign left_out  = left_r;
  assign right_out = right_r;

endmodule

// ----- src/stereo_balance_width_ramp.sv -----
`timescale 1ns / 1ps
// Stereo balance and mid/side width with per-buffer linear gain ramps.
// Input channel: one stereo frame per word (in_valid/in_ready), with the
// balance and width targets and a fading-out flag that are read only on
// the first frame of a buffer. Output channel: one processed frame per
// input word (out_valid/out_ready), saturated to the sample width.
// Configuration channel: cfg_frames_per_buffer sets the buffer length;
// it is to be written by the user only while the block is idle, which
// the block itself does not enforce. Throughput: a frame inside a buffer
// is taken every cycle while the queue is not full. The first frame of a
// buffer runs the ramp-step division, one quotient bit per cycle, and the
// input stays blocked until the division ends and that frame is pushed.
// A frame that is not the first of a buffer enters the queue at the
// accepting edge and is read out from there into four register stages
// of multiply, rebuild, balance and saturation. Reset clears the ramp
// state to zero gains at the start of a buffer and sets the buffer length
// to 1024. When the receiver stalls, the mixing pipeline holds, the
// four-word queue fills and the input is then refused.
module stereo_balance_width_ramp
  import sbwr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  len_t    cfg_frames_per_buffer,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_left_in,
  input  sample_t in_right_in,
  input  gain_t   in_target_balance,
  input  gain_t   in_target_width,
  input  logic    in_fading_out,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_left_out,
  output sample_t out_right_out
);

  len_t   fpb_r;
  logic   q_push, q_full, q_pop, q_empty;
  frame_t q_wdata, q_rdata;

  // The length register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpb_r <= len_t'(FPB_RESET);
    end else if (cfg_valid && cfg_ready) begin
      fpb_r <= cfg_frames_per_buffer;
    end
  end

  // Front end: accepts frames, steps the ramps and works out both gains.
  sbwr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .frames_per_buffer (fpb_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .left_in           (in_left_in),
    .right_in          (in_right_in),
    .target_balance    (in_target_balance),
    .target_width      (in_target_width),
    .fading_out        (in_fading_out),
    .push              (q_push),
    .push_data         (q_wdata),
    .full              (q_full)
  );

  // Short queue so that the gain generator and the mixer stall apart.
  sbwr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back end: the multiply pipeline with the output register at its end.
  sbwr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (out_left_out),
    .right_out (out_right_out)
  );

endmodule

// ----- dv/stereo_balance_width_ramp_test.sv -----
`timescale 1ns / 1ps
module stereo_balance_width_ramp_test;
  import sbwr_pkg::*;

  // Fixed-point units of the gain path, held as 64-bit values so that the
  // model below never overflows.
  localparam longint GAIN_UNIT  = longint'(1) << GAIN_FRAC_BITS;
  localparam longint RAMP_UNIT  = longint'(1) << (GAIN_FRAC_BITS + RAMP_EXTRA);
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam sample_t S_MAX     = sample_t'(SAMPLE_MAX);
  localparam sample_t S_MIN     = sample_t'(-SAMPLE_MAX - 1);
  localparam int LEN_ALL_ONES   = (1 << LEN_BITS) - 1;

  // Cycles allowed for the pipeline to settle after the last frame is seen.
  localparam int SETTLE_CYCLES  = 12;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  len_t    cfg_frames_per_buffer = '0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_left_in = '0;
  sample_t in_right_in = '0;
  gain_t   in_target_balance = '0;
  gain_t   in_target_width = '0;
  logic    in_fading_out = 1'b0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_left_out;
  sample_t out_right_out;

  stereo_balance_width_ramp dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_frames_per_buffer (cfg_frames_per_buffer),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_left_in            (in_left_in),
    .in_right_in           (in_right_in),
    .in_target_balance     (in_target_balance),
    .in_target_width       (in_target_width),
    .in_fading_out         (in_fading_out),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_left_out          (out_left_out),
    .out_right_out         (out_right_out)
  );

  always #5 clk = ~clk;

  // Our own copy of the block's ramp state and its one register. Ramp values
  // carry RAMP_EXTRA fraction bits beyond the gain format.
  len_t        ramp_len = len_t'(FPB_RESET);
  int          bal_target = 0;
  int          wid_target = 0;
  int          bal_inc = 0;
  int          wid_inc = 0;
  int          bal_ramp = 0;
  int          wid_ramp = 0;
  int unsigned buf_pos = 0;

  // Processed frames still owed by the block, oldest first.
  stereo_t expected_frames[$];

  bit stalls_on = 1'b0;
  int frames_sent = 0;
  int frames_checked = 0;
  int length_writes = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Round half up: floor of (v + half) / 2^s, the shift being arithmetic.
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic sample_t saturate(input longint v);
    return sample_t'(clip(v, -SAMPLE_MAX - 1, SAMPLE_MAX));
  endfunction

  // Latches a new target at the start of a buffer. The step is truncated
  // toward zero, and the ramp already stands one step past the old target.
  function automatic void start_ramp(inout int target_q, inout int inc, inout int ramp,
                                     input longint target, input longint len);
    longint diff;
    longint quot;
    diff = (target - longint'(target_q)) * (longint'(1) << RAMP_EXTRA);
    quot = diff / len;
    inc = int'(quot);
    ramp = int'(longint'(target_q) * (longint'(1) << RAMP_EXTRA) + quot);
    target_q = int'(target);
  endfunction

  // Works out the processed frame for one accepted input word and moves the
  // ramp state on by one frame.
  function automatic stereo_t mix_frame(input sample_t l_in, input sample_t r_in,
                                        input gain_t bal_in, input gain_t wid_in,
                                        input logic fade);
    stereo_t res;
    longint  len;
    longint  new_bal;
    longint  new_wid;
    longint  bg;
    longint  wg;
    longint  sum;
    longint  dif;
    longint  ga;
    longint  gb;
    longint  lh;
    longint  rh;
    longint  cl;
    longint  cr;
    bit      last;
    len = clip(longint'(ramp_len), 1, MAX_FRAMES);
    if (buf_pos == 0) begin
      new_bal = 0;
      new_wid = 0;
      if (!fade) begin
        new_bal = clip(longint'(bal_in), -GAIN_UNIT, GAIN_UNIT);
        new_wid = clip(longint'(wid_in), -GAIN_UNIT, GAIN_UNIT);
      end
      start_ramp(bal_target, bal_inc, bal_ramp, new_bal, len);
      start_ramp(wid_target, wid_inc, wid_ramp, new_wid, len);
    end
    last = (longint'(buf_pos) + 1 >= len);
    if (last) begin
      bg = bal_target;
      wg = wid_target;
    end else begin
      bg = clip(round_half_up(longint'(bal_ramp), RAMP_EXTRA), -GAIN_UNIT, GAIN_UNIT);
      wg = clip(round_half_up(longint'(wid_ramp), RAMP_EXTRA), -GAIN_UNIT, GAIN_UNIT);
    end
    // Width: positive widens by scaling mid, negative scales side. The
    // halving of sum and difference is folded into the first shift.
    sum = longint'(l_in) + longint'(r_in);
    dif = longint'(r_in) - longint'(l_in);
    ga = (wg > 0) ? GAIN_UNIT - wg : GAIN_UNIT;
    gb = (wg > 0) ? GAIN_UNIT : GAIN_UNIT + wg;
    lh = round_half_up(sum * ga - dif * gb, GAIN_FRAC_BITS + 1);
    rh = round_half_up(sum * ga + dif * gb, GAIN_FRAC_BITS + 1);
    // Balance: positive attenuates left, negative attenuates right.
    cl = (bg > 0) ? GAIN_UNIT - bg : GAIN_UNIT;
    cr = (bg > 0) ? GAIN_UNIT : GAIN_UNIT + bg;
    res.left = saturate(round_half_up(lh * cl, GAIN_FRAC_BITS));
    res.right = saturate(round_half_up(rh * cr, GAIN_FRAC_BITS));
    if (last) begin
      buf_pos = 0;
    end else begin
      buf_pos++;
      bal_ramp = int'(clip(longint'(bal_ramp) + longint'(bal_inc), -RAMP_UNIT, RAMP_UNIT));
      wid_ramp = int'(clip(longint'(wid_ramp) + longint'(wid_inc), -RAMP_UNIT, RAMP_UNIT));
    end
    return res;
  endfunction

  // Offers one frame word, holding it steady until the block takes it. A
  // random gap before the word is inserted only while stalls are enabled.
  task automatic send_frame(input sample_t l_in, input sample_t r_in, input gain_t bal_in,
                            input gain_t wid_in, input logic fade);
    stereo_t want;
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_left_in        <= l_in;
    in_right_in       <= r_in;
    in_target_balance <= bal_in;
    in_target_width   <= wid_in;
    in_fading_out     <= fade;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = mix_frame(l_in, r_in, bal_in, wid_in, fade);
    expected_frames.push_back(want);
    frames_sent++;
  endtask

  // The length register is only written once every owed frame has come out
  // and the pipeline has had time to settle.
  task automatic write_length(input int unsigned len);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid             <= 1'b1;
    cfg_frames_per_buffer <= len_t'(len);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ramp_len = len_t'(len);
    length_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'(longint'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Mostly legal targets, with the odd raw 16-bit value that must be clamped.
  function automatic gain_t pick_target();
    case ($urandom_range(0, 9))
      0: return gain_t'($urandom);
      1: return GAIN_ONE;
      2: return -GAIN_ONE;
      3: return '0;
      default: return gain_t'(longint'($urandom_range(0, 2 * GAIN_UNIT)) - GAIN_UNIT);
    endcase
  endfunction

  task automatic send_random_frame();
    sample_t l_in;
    sample_t r_in;
    gain_t   bal_in;
    gain_t   wid_in;
    logic    fade;
    l_in = pick_sample();
    r_in = pick_sample();
    bal_in = pick_target();
    wid_in = pick_target();
    fade = ($urandom_range(0, 7) == 0);
    send_frame(l_in, r_in, bal_in, wid_in, fade);
  endtask

  // The receiver stalls in random bursts while stalls are enabled.
  always begin
    @(posedge clk);
    if (stalls_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // Every processed word is matched against the oldest frame still owed.
  always @(posedge clk) begin
    stereo_t want;
    if (rst_n && out_valid && out_ready) begin
      frames_checked++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word left=%0d right=%0d", $realtime,
                   out_left_out, out_right_out);
      end else begin
        want = expected_frames.pop_front();
        if (out_left_out !== want.left || out_right_out !== want.right) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: word %0d: left exp %0d got %0d, right exp %0d got %0d",
                     $realtime, frames_checked, want.left, out_left_out,
                     want.right, out_right_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stereo_balance_width_ramp_test: done, errors");
      $finish;
    end
  end

  // Straight after reset the length is 1024, so these frames sit at the very
  // start of a slow ramp towards full-scale targets.
  task automatic test_reset_length();
    send_frame(S_MAX, S_MIN, GAIN_ONE, -GAIN_ONE, 1'b0);
    send_frame(S_MIN, S_MAX, GAIN_ONE, -GAIN_ONE, 1'b0);
    send_frame('0, -sample_t'(1), '0, '0, 1'b0);
  endtask

  // A length of zero acts as one, so each frame is a whole buffer and uses
  // its targets exactly. The first frame here also cuts short the buffer
  // left open above. Out-of-range targets and fading out are covered too.
  task automatic test_single_frame_buffers();
    write_length(0);
    send_frame(S_MAX, S_MAX, GAIN_ONE, GAIN_ONE, 1'b0);
    send_frame(S_MIN, S_MIN, -GAIN_ONE, -GAIN_ONE, 1'b0);
    send_frame(S_MAX, S_MIN, gain_t'(16'sh7FFF), gain_t'(16'sh8000), 1'b0);
    send_frame(S_MIN, S_MAX, gain_t'(12345), gain_t'(-777), 1'b1);
    send_frame(sample_t'(1000), sample_t'(-3000), gain_t'(-8192), gain_t'(8192), 1'b0);
  endtask

  // Two short buffers: a full swing of both gains, then a fade back to zero
  // with targets that must be ignored.
  task automatic test_short_ramps();
    int k;
    write_length(4);
    for (k = 0; k < 4; k++)
      send_frame(pick_sample(), pick_sample(), -GAIN_ONE, GAIN_ONE, 1'b0);
    for (k = 0; k < 4; k++)
      send_frame(pick_sample(), pick_sample(), GAIN_ONE, -GAIN_ONE, 1'b1);
  endtask

  // The length changes while a buffer is open. Lengthening lets the ramp run
  // past its target, where it is held at full scale; a length of all ones
  // acts as the maximum; shortening ends the buffer on the next frame.
  task automatic test_length_change();
    int k;
    write_length(2);
    send_frame(S_MAX, S_MAX, GAIN_ONE, GAIN_ONE, 1'b0);
    write_length(40);
    for (k = 0; k < 4; k++)
      send_frame(pick_sample(), pick_sample(), '0, '0, 1'b0);
    write_length(LEN_ALL_ONES);
    for (k = 0; k < 2; k++)
      send_frame(pick_sample(), pick_sample(), '0, '0, 1'b0);
    write_length(1);
    send_frame(S_MIN, S_MAX, '0, '0, 1'b0);
  endtask

  // Phases of random frames, each under a fresh buffer length. Most lengths
  // are short so that many buffers complete; phases often stop part way
  // through a buffer, so the next length lands inside an open one.
  task automatic test_random_traffic(input int total, input bit allow_idle);
    int unsigned len;
    int unsigned span;
    int          count;
    int          done_items;
    done_items = 0;
    while (done_items < total) begin
      case ($urandom_range(0, 15))
        0: len = 0;
        1: len = MAX_FRAMES;
        2: len = LEN_ALL_ONES;
        3: len = $urandom_range(0, LEN_ALL_ONES);
        4, 5, 6: len = $urandom_range(9, 64);
        default: len = $urandom_range(1, 8);
      endcase
      write_length(len);
      stalls_on = allow_idle && ($urandom_range(0, 3) != 0);
      span = (len == 0) ? 1 : ((len > MAX_FRAMES) ? MAX_FRAMES : len);
      if (span <= 8)
        count = span * $urandom_range(1, 6) + $urandom_range(0, span - 1);
      else
        count = $urandom_range(5, 40);
      if (count > 40)
        count = 40;
      if (count > total - done_items)
        count = total - done_items;
      repeat (count) send_random_frame();
      done_items += count;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length();
    test_single_frame_buffers();
    test_short_ramps();
    test_length_change();
    test_random_traffic(560, 1'b1);
    // The closing stretch runs with neither side idling.
    test_random_traffic(120, 1'b0);

    in_valid <= 1'b0;
    stalls_on = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d frames across %0d buffer length writes, %0d words checked.",
             frames_sent, length_writes, frames_checked);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0 && expected_frames.size() == 0)
      $display("stereo_balance_width_ramp_test: done, clean");
    else
      $display("stereo_balance_width_ramp_test: done, errors");
    $finish;
  end

endmodule
